FILE: hdl/fta_pkg.sv
// Package for the frame time averager: history sizing, derived widths,
// controller states and the command and status structs between the modules.
// No dependencies.
package fta_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int TICK_W = 32;
    localparam int STAMP_W = 64;
    localparam int RATE_W = 16;
    localparam int SUM_W  = TICK_W + FILL_W;
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_PERIOD      = 1'b1;

    localparam logic [TICK_W-1:0] TPS_RESET = 32'd10000000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_TEST,
        S_UPDATE,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic diff;
        logic test;
        logic update;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic locked;
        logic div_done;
        logic out_busy;
    } t_dp_status;

endpackage

FILE: hdl/frame_time_averager.sv
// Top level of the frame time averager: joins the controller and the datapath.
// Depends on fta_pkg, fta_ctrl and fta_datapath.
//
//   Channel   Signals                                   Direction
//   input     i_in_valid, o_in_stall, i_timestamp       in
//   result    o_out_valid, i_out_stall, o_frame_ticks,  out
//             o_average_ticks, o_frame_rate, o_sample_taken
//   config    i_cfg_we, i_cfg_idx, i_cfg_data           in
//
// A result passes through the DIFF, TEST, UPDATE, DIV and OUT states after its
// transfer; the input opens again once the result is in the output register,
// and the bit-serial divider that forms the mean sets most of that delay.
// A frame dropped by the lock period frees the input after DIFF and TEST.
// Reset is synchronous and needs no clearing pass; history entries are read
// only after they were written. A result waits in the output register, and a
// new frame is taken meanwhile, stalling only if a second result is ready.
module frame_time_averager
    import fta_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TICK_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [STAMP_W-1:0]   i_timestamp,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TICK_W-1:0]    o_frame_ticks,
    output logic [TICK_W-1:0]    o_average_ticks,
    output logic [RATE_W-1:0]    o_frame_rate,
    output logic                 o_sample_taken
);

    t_dp_cmd    cmd;
    t_dp_status status;

    fta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    fta_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_timestamp     (i_timestamp),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_frame_ticks   (o_frame_ticks),
        .o_average_ticks (o_average_ticks),
        .o_frame_rate    (o_frame_rate),
        .o_sample_taken  (o_sample_taken)
    );

endmodule

FILE: hdl/fta_ctrl.sv
// Controller state machine of the frame time averager.
// Depends on fta_pkg; drives the command struct of fta_datapath.
module fta_ctrl
    import fta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DIFF;
            end
            S_DIFF:   n_state = S_TEST;
            S_TEST: begin
                // A frame inside the lock period is dropped with no state change.
                n_state = i_status.locked ? S_IDLE : S_UPDATE;
            end
            S_UPDATE: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_DIFF:   o_cmd.diff = 1'b1;
            S_TEST:   o_cmd.test = 1'b1;
            S_UPDATE: o_cmd.update = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_OUT:    o_cmd.out_load = !i_status.out_busy;
            default:  o_cmd = '0;
        endcase
    end

endmodule

FILE: hdl/fta_datapath.sv
// Datapath of the frame time averager: configuration, elapsed time, history
// memory with a running sum, rate window, serial divider and output register.
// Depends on fta_pkg; sequenced by fta_ctrl.
module fta_datapath
    import fta_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TICK_W-1:0]    i_cfg_data,
    input  logic [STAMP_W-1:0]   i_timestamp,
    input  logic                 i_out_stall,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    output logic [TICK_W-1:0]    o_frame_ticks,
    output logic [TICK_W-1:0]    o_average_ticks,
    output logic [RATE_W-1:0]    o_frame_rate,
    output logic                 o_sample_taken
);

    logic [TICK_W-1:0]  r_tps;
    logic [TICK_W-1:0]  r_lock;
    logic [STAMP_W-1:0] r_stamp;
    logic [STAMP_W-1:0] r_last;
    logic [STAMP_W-1:0] r_elapsed;
    logic [STAMP_W-1:0] r_dev;
    logic [TICK_W-1:0]  r_ft;
    logic [TICK_W-1:0]  r_evict;
    logic [TICK_W-1:0]  r_hist [HISTORY_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [FILL_W-1:0]  r_fill;
    logic [SUM_W-1:0]   r_sum;
    logic [TICK_W-1:0]  r_mean;
    logic [RATE_W-1:0]  r_wframes;
    logic [TICK_W:0]    r_wticks;
    logic [RATE_W-1:0]  r_shown;
    logic               r_take;
    logic [SUM_W-1:0]   r_quo;
    logic [FILL_W-1:0]  r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic               r_out_valid;
    logic [TICK_W-1:0]  r_out_ft;
    logic [TICK_W-1:0]  r_out_avg;
    logic [RATE_W-1:0]  r_out_rate;
    logic               r_out_take;

    logic               take;
    logic               hist_full;
    logic [SUM_W-1:0]   n_sum;
    logic [RATE_W-1:0]  n_wframes;
    logic [TICK_W:0]    n_wticks;
    logic               window_close;
    logic [FILL_W:0]    div_trial;
    logic               div_fits;

    assign take      = r_dev < {{(STAMP_W-TICK_W){1'b0}}, r_tps};
    assign hist_full = r_fill == FILL_W'(HISTORY_DEPTH);

    // When the history is full, the entry about to be overwritten is the
    // oldest one and leaves the running sum.
    assign n_sum = r_sum + SUM_W'(r_ft) - (hist_full ? SUM_W'(r_evict) : '0);

    assign n_wframes    = (r_wframes == '1) ? r_wframes : r_wframes + 1'b1;
    assign n_wticks     = r_wticks + {1'b0, r_ft};
    assign window_close = n_wticks > {1'b0, r_tps};

    assign div_trial = {r_rem, r_quo[SUM_W-1]} - {1'b0, r_fill};
    assign div_fits  = !div_trial[FILL_W];

    assign o_status.locked   = (r_lock != '0) &&
                               (r_elapsed < {{(STAMP_W-TICK_W){1'b0}}, r_lock});
    assign o_status.div_done = r_div_cnt == DIV_CNT_W'(SUM_W - 1);
    assign o_status.out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps  <= TPS_RESET;
            r_lock <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TICKS_PER_SECOND: r_tps  <= i_cfg_data;
                REG_LOCK_PERIOD:      r_lock <= i_cfg_data;
                default:              r_tps  <= r_tps;
            endcase
        end
    end

    // History memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && take) begin
            r_hist[r_wr_ptr] <= r_ft;
        end
        r_evict <= r_hist[r_wr_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_stamp <= i_timestamp;
        end
        if (i_cmd.diff) begin
            r_elapsed <= r_stamp - r_last;
        end
        if (i_cmd.test) begin
            r_dev <= (r_elapsed > {{(STAMP_W-TICK_W){1'b0}}, r_mean})
                   ? r_elapsed - {{(STAMP_W-TICK_W){1'b0}}, r_mean}
                   : {{(STAMP_W-TICK_W){1'b0}}, r_mean} - r_elapsed;
            r_ft  <= (r_elapsed[STAMP_W-1:TICK_W] != '0) ? '1 : r_elapsed[TICK_W-1:0];
        end
        if (i_cmd.update) begin
            r_take    <= take;
            r_quo     <= take ? n_sum : r_sum;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[SUM_W-2:0], div_fits};
            r_rem     <= div_fits ? div_trial[FILL_W-1:0]
                                  : {r_rem[FILL_W-2:0], r_quo[SUM_W-1]};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_wr_ptr  <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_mean    <= '0;
            r_wframes <= '0;
            r_wticks  <= '0;
            r_shown   <= '0;
        end else begin
            if (i_cmd.update) begin
                r_last <= r_stamp;
                if (take) begin
                    r_sum    <= n_sum;
                    r_wr_ptr <= (r_wr_ptr == PTR_W'(HISTORY_DEPTH - 1))
                              ? '0 : r_wr_ptr + 1'b1;
                    if (!hist_full) r_fill <= r_fill + 1'b1;
                end
                if (window_close) begin
                    r_shown   <= n_wframes;
                    r_wframes <= '0;
                    r_wticks  <= '0;
                end else begin
                    r_wframes <= n_wframes;
                    r_wticks  <= n_wticks;
                end
            end
            if (i_cmd.out_load) begin
                r_mean <= (r_fill == '0) ? '0 : r_quo[TICK_W-1:0];
            end
        end
    end

    // Output register: a finished result waits here until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ft   <= r_ft;
            r_out_avg  <= (r_fill == '0) ? '0 : r_quo[TICK_W-1:0];
            r_out_rate <= r_shown;
            r_out_take <= r_take;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_ticks   = r_out_ft;
    assign o_average_ticks = r_out_avg;
    assign o_frame_rate    = r_out_rate;
    assign o_sample_taken  = r_out_take;

endmodule
